@@ design/crsf_pkg.sv @@
// Shared types, constants and the CRC-8 update function of the CRSF RC frame parser.
package crsf_pkg;

  localparam int DefMaxFrameBytes = 64;
  localparam int PayloadBytes     = 22;
  localparam int NumChannels      = 16;
  localparam int ChBits           = 11;
  localparam int MinLen           = 2;
  localparam int PtrW             = $clog2(PayloadBytes);
  localparam int AccW             = ChBits + 8;

  localparam logic [7:0] DEV_ADDR_RESET = 8'hC8;
  localparam logic [7:0] CRC_POLY       = 8'hD5;
  localparam logic [7:0] RC_TYPE        = 8'h16;

  localparam logic [1:0] KIND_CHANNEL = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_CRC_ERR = 2'd2;
  localparam logic [1:0] KIND_BAD_LEN = 2'd3;

  typedef struct packed {
    logic       take_len;
    logic       take_body;
    logic       start_unpack;
    logic       rd_issue;
    logic       rd_load;
    logic       out_load;
    logic [1:0] out_kind;
  } cmd_t;

  typedef struct packed {
    logic addr_match;
    logic len_bad;
    logic body_more;
    logic crc_ok;
    logic rc_frame;
    logic nbits_ge_ch;
    logic last_ch;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ design/crsf_datapath.sv @@
// Datapath of the CRSF parser: frame registers, CRC, payload memory, channel unpacker, output.
module crsf_datapath
  import crsf_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = DefMaxFrameBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic [7:0]  rx_byte_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [1:0]  out_kind_o,
  output logic [3:0]  out_index_o,
  output logic [10:0] out_ticks_o,
  output logic [7:0]  out_type_o,
  output logic        out_last_o
);

  logic [7:0]      dev_addr_q;
  logic [5:0]      cnt_q;
  logic [5:0]      len_q;
  logic [7:0]      crc_q;
  logic [7:0]      type_q;
  logic [7:0]      mem [PayloadBytes];
  logic [7:0]      rd_data_q;
  logic [PtrW-1:0] ptr_q;
  logic [AccW-1:0] acc_q;
  logic [4:0]      nbits_q;
  logic [3:0]      ch_q;
  logic            out_valid_q;
  logic [1:0]      out_kind_q;
  logic [3:0]      out_index_q;
  logic [10:0]     out_ticks_q;
  logic [7:0]      out_type_q;
  logic            out_last_q;

  logic            emit_ch;
  logic            wr_en;
  logic [PtrW-1:0] wr_addr;

  assign emit_ch = cmd_i.out_load && (cmd_i.out_kind == KIND_CHANNEL);
  assign wr_en   = cmd_i.take_body && (cnt_q != 6'd0) && (cnt_q <= 6'(PayloadBytes));
  assign wr_addr = PtrW'(cnt_q - 6'd1);

  always_comb begin
    sts_o.addr_match  = (rx_byte_i == dev_addr_q);
    sts_o.len_bad     = (rx_byte_i < 8'(MinLen)) ||
                        (({1'b0, rx_byte_i} + 9'd2) > 9'(MAX_FRAME_BYTES));
    sts_o.body_more   = (({1'b0, cnt_q} + 7'd1) < {1'b0, len_q});
    sts_o.crc_ok      = (crc_q == rx_byte_i);
    sts_o.rc_frame    = (type_q == RC_TYPE) && (len_q >= 6'(PayloadBytes + 2));
    sts_o.nbits_ge_ch = (nbits_q >= 5'(ChBits));
    sts_o.last_ch     = (ch_q == 4'(NumChannels - 1));
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEV_ADDR_RESET;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      len_q  <= '0;
      crc_q  <= '0;
      type_q <= '0;
    end else if (cmd_i.take_len) begin
      len_q <= rx_byte_i[5:0];
      cnt_q <= '0;
      crc_q <= '0;
    end else if (cmd_i.take_body) begin
      crc_q <= crc8_update(crc_q, rx_byte_i);
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd0) begin
        type_q <= rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= rx_byte_i;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      acc_q   <= '0;
      nbits_q <= '0;
      ch_q    <= '0;
    end else if (cmd_i.start_unpack) begin
      ptr_q   <= '0;
      acc_q   <= '0;
      nbits_q <= '0;
      ch_q    <= '0;
    end else begin
      if (cmd_i.rd_issue) begin
        ptr_q <= ptr_q + PtrW'(1);
      end
      if (cmd_i.rd_load) begin
        acc_q   <= acc_q | (AccW'(rd_data_q) << nbits_q);
        nbits_q <= nbits_q + 5'd8;
      end else if (emit_ch) begin
        acc_q   <= acc_q >> ChBits;
        nbits_q <= nbits_q - 5'(ChBits);
        ch_q    <= ch_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.out_kind;
      if (emit_ch) begin
        out_index_q <= ch_q;
        out_ticks_q <= acc_q[ChBits-1:0];
        out_type_q  <= type_q;
        out_last_q  <= sts_o.last_ch;
      end else begin
        out_index_q <= '0;
        out_ticks_q <= '0;
        out_type_q  <= (cmd_i.out_kind == KIND_BAD_LEN) ? 8'd0 : type_q;
        out_last_q  <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_index_o = out_index_q;
  assign out_ticks_o = out_ticks_q;
  assign out_type_o  = out_type_q;
  assign out_last_o  = out_last_q;

endmodule

@@ design/crsf_controller.sv @@
// Controller of the CRSF parser: frame phases and the channel unpack sequence.
module crsf_controller
  import crsf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] ST_HUNT = 3'd0;
  localparam logic [2:0] ST_LEN  = 3'd1;
  localparam logic [2:0] ST_BODY = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_LD   = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       fire;

  always_comb begin
    unique case (state_q) inside
      ST_HUNT:         in_ready_o = 1'b1;
      ST_LEN, ST_BODY: in_ready_o = sts_i.out_free;
      default:         in_ready_o = 1'b0;
    endcase
  end

  assign fire = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_HUNT: begin
        if (fire) begin
          state_d = sts_i.addr_match ? ST_LEN : ST_HUNT;
        end
      end
      ST_LEN: begin
        if (fire) begin
          if (sts_i.len_bad) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_kind = KIND_BAD_LEN;
            state_d        = sts_i.addr_match ? ST_LEN : ST_HUNT;
          end else begin
            cmd_o.take_len = 1'b1;
            state_d        = ST_BODY;
          end
        end
      end
      ST_BODY: begin
        if (fire) begin
          if (sts_i.body_more) begin
            cmd_o.take_body = 1'b1;
          end else if (!sts_i.crc_ok) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_kind = KIND_CRC_ERR;
            state_d        = ST_HUNT;
          end else if (sts_i.rc_frame) begin
            cmd_o.start_unpack = 1'b1;
            state_d            = ST_RD;
          end else begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_kind = KIND_GOOD;
            state_d        = ST_HUNT;
          end
        end
      end
      ST_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_LD;
      end
      ST_LD: begin
        cmd_o.rd_load = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (!sts_i.nbits_ge_ch) begin
          state_d = ST_RD;
        end else if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_CHANNEL;
          if (sts_i.last_ch) begin
            state_d = ST_HUNT;
          end
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/crsf_rc_frame_parser.sv @@
// Top level of the CRSF RC frame parser: controller plus datapath.
//
// Slave stream: one received serial byte per word on s_axis_tdata[7:0].
// Master stream: one result per word; tuser carries the result kind
// (channel value, other good frame, CRC error, bad length) and tlast marks
// the final result caused by one input byte.
// cfg_we_i/cfg_wdata_i write the device address that starts a frame.
// An input byte is taken whenever s_axis_tready is high. A byte that causes a single
// result loads the output register at the same edge at which it is taken.
// A good RC channels frame reads its 22 stored payload bytes through the
// single memory read port, issuing each read, then loading the byte into
// the accumulator, then shifting out 11-bit values while enough bits are held,
// sixteen channel words in all; no byte is taken meanwhile.
// A stalled receiver holds the output word; past the address byte no byte
// is taken until the output register is free, address hunting goes on.
// Reset returns to address hunting, empties the output register and sets
// the device address to 0xC8; the payload memory is not cleared.
module crsf_rc_frame_parser
  import crsf_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = DefMaxFrameBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [3:0] channel_index, [14:4] channel_ticks,
                                      // [22:15] frame_type, [23] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last_of_run
);

  cmd_t        cmd;
  sts_t        sts;
  logic [3:0]  out_index;
  logic [10:0] out_ticks;
  logic [7:0]  out_type;

  crsf_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crsf_datapath #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_byte_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (m_axis_tuser),
    .out_index_o (out_index),
    .out_ticks_o (out_ticks),
    .out_type_o  (out_type),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_type, out_ticks, out_index};

endmodule
